// ----- hdl/sed_pkg.sv -----
// ----------------------------------------------------------------------------
// sed_pkg: shared types and constants of the swallow event detector
// Register indexes, reset values, and the sample, config and result records.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned PIEZO_W = 10;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned LIMIT_W = 15;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned COUNT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_PIEZO_THR  = 3'd0,
    IDX_GYRO_LIM_X = 3'd1,
    IDX_GYRO_LIM_Y = 3'd2,
    IDX_GYRO_LIM_Z = 3'd3,
    IDX_BLANK_MS   = 3'd4,
    IDX_REFRACT_MS = 3'd5
  } cfg_idx_e;

  localparam logic [PIEZO_W-1:0] PIEZO_THR_RST  = 10'd512;
  localparam logic [LIMIT_W-1:0] GYRO_LIM_RST   = 15'd256;
  localparam logic [MS_W-1:0]    BLANK_MS_RST   = 16'd50;
  localparam logic [MS_W-1:0]    REFRACT_MS_RST = 16'd2000;

  typedef struct packed {
    logic [PIEZO_W-1:0] piezo_thr;
    logic [LIMIT_W-1:0] lim_x;
    logic [LIMIT_W-1:0] lim_y;
    logic [LIMIT_W-1:0] lim_z;
    logic [MS_W-1:0]    blank_ms;
    logic [MS_W-1:0]    refract_ms;
  } cfg_t;

  typedef struct packed {
    logic [PIEZO_W-1:0]       piezo;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
    logic [STAMP_W-1:0]       stamp;
  } sample_t;

  typedef struct packed {
    logic               found;
    logic [STAMP_W-1:0] last_ms;
    logic [COUNT_W-1:0] total;
  } result_t;

endpackage

// ----- hdl/sed_cfg.sv -----
// ----------------------------------------------------------------------------
// sed_cfg: configuration registers
// Holds thresholds and timing settings, written through a plain write port.
// ----------------------------------------------------------------------------
module sed_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [sed_pkg::CFG_IDX_W-1:0]   idx_i,
  input  logic [sed_pkg::CFG_DATA_W-1:0]  data_i,
  output sed_pkg::cfg_t                   cfg_o
);
  import sed_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        IDX_PIEZO_THR:  cfg_d.piezo_thr  = data_i[PIEZO_W-1:0];
        IDX_GYRO_LIM_X: cfg_d.lim_x      = data_i[LIMIT_W-1:0];
        IDX_GYRO_LIM_Y: cfg_d.lim_y      = data_i[LIMIT_W-1:0];
        IDX_GYRO_LIM_Z: cfg_d.lim_z      = data_i[LIMIT_W-1:0];
        IDX_BLANK_MS:   cfg_d.blank_ms   = data_i[MS_W-1:0];
        IDX_REFRACT_MS: cfg_d.refract_ms = data_i[MS_W-1:0];
        default:        cfg_d = cfg_q;  // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.piezo_thr  <= PIEZO_THR_RST;
      cfg_q.lim_x      <= GYRO_LIM_RST;
      cfg_q.lim_y      <= GYRO_LIM_RST;
      cfg_q.lim_z      <= GYRO_LIM_RST;
      cfg_q.blank_ms   <= BLANK_MS_RST;
      cfg_q.refract_ms <= REFRACT_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/sed_core.sv -----
// ----------------------------------------------------------------------------
// sed_core: detection logic and event state
// Evaluates one sample against the piezo threshold, the blanking window and the
// refractory gap and updates the event state when the sample moves on.
// ----------------------------------------------------------------------------
module sed_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  sed_pkg::sample_t sample_i,
  input  sed_pkg::cfg_t    cfg_i,
  output sed_pkg::result_t result_o
);
  import sed_pkg::*;

  logic [STAMP_W-1:0] blank_until_q, blank_until_d;
  logic [STAMP_W-1:0] last_time_q, last_time_d;
  logic               seen_q, seen_d;
  logic [COUNT_W-1:0] count_q, count_d;

  logic [RATE_W:0]    mag_x, mag_y, mag_z;
  logic               motion;
  logic [STAMP_W:0]   blank_sum;
  logic               blank_ok;
  logic [STAMP_W-1:0] gap;
  logic               found;

  // magnitude needs one extra bit for full-scale negative
  function automatic logic [RATE_W:0] rate_mag(input logic signed [RATE_W-1:0] r);
    logic [RATE_W:0] ext;
    ext = {r[RATE_W-1], r};
    return r[RATE_W-1] ? (~ext + 1'b1) : ext;
  endfunction

  always_comb begin
    mag_x  = rate_mag(sample_i.rate_x);
    mag_y  = rate_mag(sample_i.rate_y);
    mag_z  = rate_mag(sample_i.rate_z);
    motion = (mag_x > {2'b00, cfg_i.lim_x}) ||
             (mag_y > {2'b00, cfg_i.lim_y}) ||
             (mag_z > {2'b00, cfg_i.lim_z});

    blank_sum = {1'b0, sample_i.stamp} + {{(STAMP_W+1-MS_W){1'b0}}, cfg_i.blank_ms};
    // With fresh motion, stamp >= stamp + blank only when blank is zero or the
    // sum wrapped past the top of the timer.
    if (motion) begin
      blank_ok = (cfg_i.blank_ms == '0) || blank_sum[STAMP_W];
    end else begin
      blank_ok = (sample_i.stamp >= blank_until_q);
    end

    gap   = sample_i.stamp - last_time_q;
    found = (sample_i.piezo > cfg_i.piezo_thr) && blank_ok &&
            (!seen_q || (gap > {{(STAMP_W-MS_W){1'b0}}, cfg_i.refract_ms}));

    blank_until_d = motion ? blank_sum[STAMP_W-1:0] : blank_until_q;
    seen_d        = seen_q || found;
    last_time_d   = found ? sample_i.stamp : last_time_q;
    count_d       = count_q;
    if (found && (count_q != '1)) begin
      count_d = count_q + 1'b1;
    end

    result_o.found   = found;
    result_o.last_ms = last_time_d;
    result_o.total   = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_until_q <= '0;
      last_time_q   <= '0;
      seen_q        <= 1'b0;
      count_q       <= '0;
    end else if (step_i) begin
      blank_until_q <= blank_until_d;
      last_time_q   <= last_time_d;
      seen_q        <= seen_d;
      count_q       <= count_d;
    end
  end

endmodule

// ----- hdl/swallow_event_detector.sv -----
// ----------------------------------------------------------------------------
// swallow_event_detector: piezo swallow detection with gyro blanking
// Top level: input register, detection core, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one timestamped sample:
//   piezo reading, three gyro rates and a millisecond stamp. Output channel
//   (out_valid_o / out_stall_i) returns one result item per sample: the
//   detect flag, the time of the last swallow and the saturating count.
//   An accepted sample sits in the input register, where the compare logic and
//   the event state see it, then moves into the result register, where the
//   result is held until the receiver takes it. Throughput is one item per
//   cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds its item and the
//   input register fills; in_stall_o rises only when both are full and the
//   receiver stalls.
//   Reset empties both pipeline registers, clears the event state (no event
//   seen, count zero) and loads the default thresholds. Write configuration
//   through cfg_we_i / cfg_idx_i / cfg_data_i only while no item is in flight.
// ----------------------------------------------------------------------------
module swallow_event_detector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sed_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sed_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sed_pkg::PIEZO_W-1:0]     piezo_sample_i,
  input  logic signed [sed_pkg::RATE_W-1:0] rate_x_i,
  input  logic signed [sed_pkg::RATE_W-1:0] rate_y_i,
  input  logic signed [sed_pkg::RATE_W-1:0] rate_z_i,
  input  logic [sed_pkg::STAMP_W-1:0]     stamp_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            swallow_found_o,
  output logic [sed_pkg::STAMP_W-1:0]     last_swallow_ms_o,
  output logic [sed_pkg::COUNT_W-1:0]     swallow_total_o
);
  import sed_pkg::*;

  cfg_t    cfg;
  sample_t smp_q;
  logic    smp_valid_q;
  result_t core_res;
  result_t res_q;
  logic    res_valid_q;
  logic    advance;
  logic    in_take;

  sed_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // move the staged sample into the result register when it has room
  assign advance    = smp_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = smp_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  sed_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .sample_i (smp_q),
    .cfg_i    (cfg),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        smp_valid_q <= 1'b1;
      end else if (advance) begin
        smp_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      smp_q.piezo  <= piezo_sample_i;
      smp_q.rate_x <= rate_x_i;
      smp_q.rate_y <= rate_y_i;
      smp_q.rate_z <= rate_z_i;
      smp_q.stamp  <= stamp_ms_i;
    end
    if (advance) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o       = res_valid_q;
  assign swallow_found_o   = res_q.found;
  assign last_swallow_ms_o = res_q.last_ms;
  assign swallow_total_o   = res_q.total;

  // input side backs up only behind a stalled, full result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_found_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && swallow_found_o) |-> (swallow_total_o != '0))
    else $error("swallow reported with zero count");

  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) ##1 out_valid_o |->
      (swallow_total_o >= $past(swallow_total_o)))
    else $error("swallow count decreased between items");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) ##1 (out_valid_o && !swallow_found_o) |->
      (swallow_total_o == $past(swallow_total_o)) &&
      (last_swallow_ms_o == $past(last_swallow_ms_o)))
    else $error("event state changed without a swallow");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the swallow event detector
// Feeds timestamped piezo and gyro samples through the valid/stall channels,
// predicts each result from a local copy of the event state and settings,
// and checks every result item in order. Runs directed corner samples, then
// random phases under several register settings, extremes and a run where
// every sample is a swallow among them.
// ----------------------------------------------------------------------------
module tb_top;
  import sed_pkg::*;

  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_B = 3'd7;
  localparam logic [STAMP_W-1:0]   SAT_BASE     = 32'h4000_0000;
  localparam int                   SAT_ITEMS    = 30;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [PIEZO_W-1:0]     piezo = '0;
  logic signed [RATE_W-1:0] rate_x = '0;
  logic signed [RATE_W-1:0] rate_y = '0;
  logic signed [RATE_W-1:0] rate_z = '0;
  logic [STAMP_W-1:0]     stamp = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   found;
  logic [STAMP_W-1:0]     last_ms;
  logic [COUNT_W-1:0]     total;

  // predicted event state and register copy
  cfg_t                   cfg_shadow;
  logic [STAMP_W-1:0]     blank_until_ms = '0;
  logic [STAMP_W-1:0]     last_event_ms = '0;
  logic                   swallow_seen = 1'b0;
  logic [COUNT_W-1:0]     event_total = '0;

  sample_t                pending_q[$];
  result_t                expected_q[$];
  logic [STAMP_W-1:0]     clock_ms = '0;
  logic                   in_took = 1'b0;
  logic                   steady = 1'b0;
  int                     fault_count = 0;

  swallow_event_detector i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .piezo_sample_i    (piezo),
    .rate_x_i          (rate_x),
    .rate_y_i          (rate_y),
    .rate_z_i          (rate_z),
    .stamp_ms_i        (stamp),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .swallow_found_o   (found),
    .last_swallow_ms_o (last_ms),
    .swallow_total_o   (total)
  );

  always #10 clk = ~clk;

  function automatic int rate_mag(input logic signed [RATE_W-1:0] r);
    return (r < 0) ? -int'(r) : int'(r);
  endfunction

  function automatic result_t swallow_predict(input sample_t s);
    result_t            r;
    logic [STAMP_W-1:0] gap;
    if (rate_mag(s.rate_x) > int'(cfg_shadow.lim_x) ||
        rate_mag(s.rate_y) > int'(cfg_shadow.lim_y) ||
        rate_mag(s.rate_z) > int'(cfg_shadow.lim_z)) begin
      blank_until_ms = s.stamp + STAMP_W'(cfg_shadow.blank_ms);
    end
    gap = s.stamp - last_event_ms;
    r.found = 1'b0;
    if (s.piezo > cfg_shadow.piezo_thr && s.stamp >= blank_until_ms &&
        (!swallow_seen || gap > STAMP_W'(cfg_shadow.refract_ms))) begin
      r.found = 1'b1;
    end
    if (r.found) begin
      swallow_seen = 1'b1;
      last_event_ms = s.stamp;
      if (event_total != '1) begin
        event_total = event_total + 1'b1;
      end
    end
    r.last_ms = last_event_ms;
    r.total = event_total;
    return r;
  endfunction

  function automatic logic signed [RATE_W-1:0] pick_rate(input logic [LIMIT_W-1:0] lim);
    int roll;
    int l;
    int m;
    roll = $urandom_range(99);
    l = int'(lim);
    if (roll < 95) begin
      return RATE_W'(int'($urandom_range(0, 2 * l)) - l);
    end
    if (roll < 98) begin
      // just past the limit, either sign
      m = l + 1 + int'($urandom_range(0, 2));
      if (m > 32768) begin
        m = 32768;
      end
      return RATE_W'(($urandom_range(1) == 1) ? -m : m);
    end
    return RATE_W'($urandom());
  endfunction

  task push_sample(input logic [PIEZO_W-1:0] p, input logic signed [RATE_W-1:0] rx,
                   input logic signed [RATE_W-1:0] ry, input logic signed [RATE_W-1:0] rz,
                   input logic [STAMP_W-1:0] st);
    sample_t s;
    s.piezo = p;
    s.rate_x = rx;
    s.rate_y = ry;
    s.rate_z = rz;
    s.stamp = st;
    pending_q.push_back(s);
  endtask

  // call at a falling edge while nothing is in flight
  task set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      IDX_PIEZO_THR:  cfg_shadow.piezo_thr = data[PIEZO_W-1:0];
      IDX_GYRO_LIM_X: cfg_shadow.lim_x = data[LIMIT_W-1:0];
      IDX_GYRO_LIM_Y: cfg_shadow.lim_y = data[LIMIT_W-1:0];
      IDX_GYRO_LIM_Z: cfg_shadow.lim_z = data[LIMIT_W-1:0];
      IDX_BLANK_MS:   cfg_shadow.blank_ms = data[MS_W-1:0];
      IDX_REFRACT_MS: cfg_shadow.refract_ms = data[MS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task set_all(input logic [CFG_DATA_W-1:0] data);
    set_reg(IDX_PIEZO_THR, data);
    set_reg(IDX_GYRO_LIM_X, data);
    set_reg(IDX_GYRO_LIM_Y, data);
    set_reg(IDX_GYRO_LIM_Z, data);
    set_reg(IDX_BLANK_MS, data);
    set_reg(IDX_REFRACT_MS, data);
  endtask

  task random_config();
    set_reg(IDX_PIEZO_THR, CFG_DATA_W'($urandom()));
    set_reg(IDX_GYRO_LIM_X, CFG_DATA_W'($urandom_range(0, 3000)));
    set_reg(IDX_GYRO_LIM_Y, CFG_DATA_W'($urandom_range(0, 3000)));
    set_reg(IDX_GYRO_LIM_Z, CFG_DATA_W'($urandom_range(0, 3000)));
    set_reg(IDX_BLANK_MS, CFG_DATA_W'($urandom_range(0, 400)));
    set_reg(IDX_REFRACT_MS, CFG_DATA_W'($urandom_range(0, 3000)));
  endtask

  task queue_random(input int n);
    logic [PIEZO_W-1:0] p;
    int                 roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 85) begin
        clock_ms += $urandom_range(0, cfg_shadow.refract_ms / 2 + 64);
      end else if (roll < 93) begin
        clock_ms += $urandom_range(0, cfg_shadow.refract_ms + cfg_shadow.blank_ms + 3000);
      end else if (roll < 97) begin
        clock_ms += $urandom();
      end else begin
        // arbitrary time, may step back
        clock_ms = $urandom();
      end
      if ($urandom_range(1) == 1 && cfg_shadow.piezo_thr != '1) begin
        p = PIEZO_W'($urandom_range(cfg_shadow.piezo_thr + 1, 1023));
      end else begin
        p = PIEZO_W'($urandom_range(0, 1023));
      end
      push_sample(p, pick_rate(cfg_shadow.lim_x), pick_rate(cfg_shadow.lim_y),
                  pick_rate(cfg_shadow.lim_z), clock_ms);
    end
  endtask

  task drain();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // driver: present the next item once the current one is taken
  always @(negedge clk) begin
    sample_t head;
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (pending_q.size() != 0 && (steady || $urandom_range(99) >= 14)) begin
          head = pending_q.pop_front();
          piezo <= head.piezo;
          rate_x <= head.rate_x;
          rate_y <= head.rate_y;
          rate_z <= head.rate_z;
          stamp <= head.stamp;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 14);
    end
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    sample_t s;
    result_t want;
    if (rst_n) begin
      in_took = in_valid && !in_stall;
      if (in_took) begin
        s.piezo = piezo;
        s.rate_x = rate_x;
        s.rate_y = rate_y;
        s.rate_z = rate_z;
        s.stamp = stamp;
        expected_q.push_back(swallow_predict(s));
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("%0t: result with none expected: found=%0b last=%0d total=%0d",
                     $realtime, found, last_ms, total);
          end
        end else begin
          want = expected_q.pop_front();
          if (want.found !== found || want.last_ms !== last_ms || want.total !== total) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("%0t: mismatch: expected found=%0b last=%0d total=%0d,",
                       $realtime, want.found, want.last_ms, want.total,
                       " got found=%0b last=%0d total=%0d", found, last_ms, total);
            end
          end
        end
      end
    end
  end

  initial begin
    cfg_shadow.piezo_thr = PIEZO_THR_RST;
    cfg_shadow.lim_x = GYRO_LIM_RST;
    cfg_shadow.lim_y = GYRO_LIM_RST;
    cfg_shadow.lim_z = GYRO_LIM_RST;
    cfg_shadow.blank_ms = BLANK_MS_RST;
    cfg_shadow.refract_ms = REFRACT_MS_RST;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: threshold 512, limits 256, blank 50, refractory 2000
    push_sample(10'd0, 16'sd0, 16'sd0, 16'sd0, 32'd0);
    push_sample(10'd512, 16'sd0, 16'sd0, 16'sd0, 32'd10);
    push_sample(10'd513, 16'sd256, -16'sd256, 16'sd256, 32'd20);
    push_sample(10'd1023, 16'sd0, 16'sd0, 16'sd0, 32'd2020);
    push_sample(10'd1023, 16'sd0, 16'sd0, 16'sd0, 32'd2021);
    push_sample(10'd1023, 16'sd257, 16'sd0, 16'sd0, 32'd5000);
    push_sample(10'd1023, 16'sd0, -16'sd257, 16'sd0, 32'd6000);
    push_sample(10'd1023, 16'sd0, 16'sd0, 16'sh8000, 32'd7000);
    push_sample(10'd1023, 16'sd0, 16'sd0, 16'sd0, 32'd7049);
    push_sample(10'd1023, 16'sd0, 16'sd0, 16'sd0, 32'd7050);
    push_sample(10'd1023, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd9100);
    push_sample(10'd1023, 16'sh8000, 16'sh8000, 16'sh8000, 32'd9200);
    push_sample(10'd700, -16'sd1, -16'sd1, -16'sd1, 32'd9250);
    // blanking end wraps past zero
    push_sample(10'd1023, 16'sd0, 16'sd0, 16'sd300, 32'hFFFF_FFF0);
    push_sample(10'd1023, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0010);
    push_sample(10'd1023, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0800);
    push_sample(10'h2AA, 16'sh2AAA, 16'sh5555, -16'sd255, 32'hAAAA_AAAA);
    push_sample(10'h155, 16'sh5555, 16'sh2AAA, 16'sh00FF, 32'h5555_5555);
    clock_ms = 32'h5555_6000;
    drain();

    random_config();
    set_reg(IDX_UNUSED_A, CFG_DATA_W'($urandom()));
    set_reg(IDX_UNUSED_B, CFG_DATA_W'($urandom()));
    queue_random(300);
    drain();

    // low extremes; zero blanking lets a moving sample still count
    set_all(16'h0000);
    clock_ms += 10;
    push_sample(10'd1, 16'sh8000, 16'sd0, 16'sd0, clock_ms);
    clock_ms += 1;
    push_sample(10'd1023, 16'sd0, 16'sd5, 16'sd0, clock_ms);
    queue_random(80);
    drain();

    // high extremes, upper data bits set too
    set_all(16'hFFFF);
    queue_random(60);
    drain();

    // long stretch with no idling on either side
    steady = 1'b1;
    random_config();
    queue_random(260);
    drain();
    steady = 1'b0;

    // every sample a swallow, with or without motion
    set_reg(IDX_PIEZO_THR, 16'h0000);
    set_reg(IDX_GYRO_LIM_X, 16'h7FFF);
    set_reg(IDX_GYRO_LIM_Y, 16'h7FFF);
    set_reg(IDX_GYRO_LIM_Z, 16'h7FFF);
    set_reg(IDX_BLANK_MS, 16'h0000);
    set_reg(IDX_REFRACT_MS, 16'h0000);
    clock_ms = SAT_BASE;
    push_sample(10'd1023, 16'sh8000, 16'sd0, 16'sd0, clock_ms);
    for (int k = 0; k < SAT_ITEMS; k++) begin
      clock_ms += $urandom_range(1, 8);
      push_sample(PIEZO_W'($urandom_range(1, 1023)),
                  RATE_W'(int'($urandom_range(0, 65534)) - 32767),
                  RATE_W'(int'($urandom_range(0, 65534)) - 32767),
                  RATE_W'(int'($urandom_range(0, 65534)) - 32767), clock_ms);
    end
    drain();

    random_config();
    queue_random(200);
    drain();

    if (fault_count == 0) begin
      $display("swallow_event_detector verification clean");
    end else begin
      $display("swallow_event_detector verification failed");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("swallow_event_detector verification failed");
    $finish;
  end

endmodule
